### src/fng_pkg.sv
// Shared constants and types for the fractional-N word generator.
`timescale 1ns / 1ps
package fng_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_REF_FREQ  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REF_DIV   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_EN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_GAIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IF_OFFSET = 3'd4;

  // Configuration reset values
  localparam logic [30:0] RST_REF_FREQ  = 31'd19200000;
  localparam logic [11:0] RST_REF_DIV   = 12'd3;
  localparam logic [30:0] RST_IF_OFFSET = 31'd73350000;

  // Frequency datapath widths
  localparam int FREQ_W = 31;
  localparam int QUO_W  = 32;

  // Integer divider offset and legal range of the rounded quotient
  localparam logic [31:0] INT_OFFSET = 32'd32;
  localparam logic [31:0] INT_TOP    = 32'd4127;

  // Register address nibbles
  localparam logic [3:0] ADDR_INT      = 4'h0;
  localparam logic [3:0] ADDR_FRAC_MSB = 4'h1;
  localparam logic [3:0] ADDR_FRAC_LSB = 4'h2;
  localparam logic [3:0] ADDR_REF_DIV  = 4'h5;
  localparam logic [3:0] ADDR_CTRL     = 4'h6;
  localparam logic [3:0] ADDR_R7       = 4'h7;
  localparam logic [3:0] ADDR_R8       = 4'h8;
  localparam logic [3:0] ADDR_R9       = 4'h9;

  // Word slots in the emitted sequence
  localparam logic [2:0] SLOT_REF_DIV  = 3'd0;
  localparam logic [2:0] SLOT_CTRL     = 3'd1;
  localparam logic [2:0] SLOT_R7       = 3'd2;
  localparam logic [2:0] SLOT_R8       = 3'd3;
  localparam logic [2:0] SLOT_R9       = 3'd4;
  localparam logic [2:0] SLOT_INT      = 3'd5;
  localparam logic [2:0] SLOT_FRAC_LSB = 3'd6;
  localparam logic [2:0] SLOT_FRAC_MSB = 3'd7;

  // Finished item handed to the word serializer
  typedef struct packed {
    logic        fpd_zero;
    logic        err;
    logic [11:0] int_word;
    logic [11:0] frac_msb;
    logic [7:0]  frac_lsb;
  } ser_load_t;

  // Live configuration fields that appear in the word sequence
  typedef struct packed {
    logic [11:0] ref_div;
    logic        lock_en;
    logic [4:0]  pump_gain;
  } ctrl_fields_t;

endpackage

### src/fng_if.sv
// Request and register-word channel interfaces.
`timescale 1ns / 1ps
interface fng_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [30:0] target_frequency;
  modport source (output valid, output mode, output target_frequency, input ready);
  modport sink   (input valid, input mode, input target_frequency, output ready);
endinterface

interface fng_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] register_word;
  logic        last_word;
  logic        error;
  modport source (output valid, output register_word, output last_word, output error,
                  input ready);
  modport sink   (input valid, input register_word, input last_word, input error,
                  output ready);
endinterface

### src/fng_fpd_unit.sv
// Iterative divider for the phase-detector frequency, one quotient bit a cycle.
`timescale 1ns / 1ps
module fng_fpd_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] ref_freq,
  input  logic [11:0] ref_div,
  output logic [30:0] fpd,
  output logic        busy
);
  import fng_pkg::*;

  logic        pending;
  logic        running;
  logic [4:0]  cnt;
  logic [12:0] rem;
  logic [30:0] quo;
  logic [12:0] divisor;
  logic [13:0] trial;
  logic        ge;

  assign divisor = 13'(ref_div) + 13'd1;
  assign trial   = {rem, quo[30]};
  assign ge      = trial >= {1'b0, divisor};
  assign busy    = pending | running;

  // Sequence the division after reset and after every configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b1;
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      pending <= 1'b1;
      running <= 1'b0;
    end else if (pending) begin
      pending <= 1'b0;
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd30) begin
        running <= 1'b0;
      end
    end
  end

  // Shift remainder and quotient, latch the result on the last step
  always_ff @(posedge clk) begin
    if (pending) begin
      rem <= '0;
      quo <= ref_freq;
    end else if (running) begin
      rem <= ge ? 13'(trial - {1'b0, divisor}) : trial[12:0];
      quo <= {quo[29:0], ge};
      if (cnt == 5'd30) begin
        fpd <= {quo[29:0], ge};
      end
    end
  end

endmodule

### src/fng_div_cell.sv
// One restoring-division cell: brings in one dividend bit, yields one quotient bit.
`timescale 1ns / 1ps
module fng_div_cell #(
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [30:0]   fpd,
  input  logic          vld_in,
  input  logic [30:0]   rem_in,
  input  logic [DW-1:0] dvd_in,
  input  logic [DW-1:0] quo_in,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [30:0]   rem_out,
  output logic [DW-1:0] dvd_out,
  output logic [DW-1:0] quo_out,
  output logic [SW-1:0] side_out
);
  logic [31:0] trial;
  logic        ge;
  logic [31:0] diff;

  assign trial = {rem_in, dvd_in[DW-1]};
  assign ge    = trial >= {1'b0, fpd};
  assign diff  = trial - {1'b0, fpd};

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (adv) begin
      vld_out <= vld_in;
    end
  end

  // Advance the partial remainder and hand it to the next cell
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out  <= ge ? diff[30:0] : trial[30:0];
      dvd_out  <= dvd_in << 1;
      quo_out  <= {quo_in[DW-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

### src/fng_serializer.sv
// Emits the eight register words of one item, or a single error word.
`timescale 1ns / 1ps
module fng_serializer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tail_valid,
  input  fng_pkg::ser_load_t    load,
  input  fng_pkg::ctrl_fields_t ctrl,
  output logic                  can_load,
  fng_out_if.source             out_item
);
  import fng_pkg::*;

  logic      busy;
  logic [2:0] slot;
  ser_load_t cur;
  logic      last;
  logic      take;

  assign last     = cur.fpd_zero | (slot == SLOT_FRAC_MSB);
  assign can_load = !busy | (out_item.ready & last);
  assign take     = tail_valid & can_load;

  // Step through the word slots
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (take) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (busy && out_item.ready) begin
      if (last) begin
        busy <= 1'b0;
      end
      slot <= slot + 3'd1;
    end
  end

  // Hold the finished item
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= load;
    end
  end

  // Build the word for the current slot
  always_comb begin
    out_item.valid     = busy;
    out_item.last_word = last;
    out_item.error     = cur.fpd_zero | cur.err;
    if (cur.fpd_zero) begin
      out_item.register_word = '0;
    end else begin
      case (slot)
        SLOT_REF_DIV:  out_item.register_word = {ADDR_REF_DIV, ctrl.ref_div};
        SLOT_CTRL:     out_item.register_word = {ADDR_CTRL, 6'd0, ctrl.lock_en,
                                                 ctrl.pump_gain};
        SLOT_R7:       out_item.register_word = {ADDR_R7, 12'd0};
        SLOT_R8:       out_item.register_word = {ADDR_R8, 12'd0};
        SLOT_R9:       out_item.register_word = {ADDR_R9, 12'd0};
        SLOT_INT:      out_item.register_word = {ADDR_INT, cur.int_word};
        SLOT_FRAC_LSB: out_item.register_word = {ADDR_FRAC_LSB, 4'd0, cur.frac_lsb};
        default:       out_item.register_word = {ADDR_FRAC_MSB, cur.frac_msb};
      endcase
    end
  end

endmodule

### src/fractional_n_word_generator_top.sv
// Top level of the fractional-N synthesizer register word generator.
`timescale 1ns / 1ps
// Each accepted request (mode, target frequency) yields eight 16-bit register words, or one
// error word when the detector frequency is zero. New requests are taken while earlier ones
// are in the chain; the chain stalls when the word serializer cannot take its tail. The
// quotient and fraction are worked out by a chain of 32 + FRACTION_BITS division cells, one
// quotient bit per cell, with a register for remainder magnitude and integer word between
// the quotient and fraction cells. The detector frequency comes from an iterative divider
// that runs after reset and every configuration write; requests are held off while it runs.
module fractional_n_word_generator_top #(
  parameter int FRACTION_BITS = 18
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fng_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fng_pkg::CFG_DATA_W-1:0]  cfg_data,
  fng_in_if.sink                          in_item,
  fng_out_if.source                       out_item
);
  import fng_pkg::*;

  localparam int SIDE_W = 15;

  // Configuration registers
  logic [30:0] ref_freq;
  logic [11:0] ref_div;
  logic        lock_en;
  logic [4:0]  pump_gain;
  logic [30:0] if_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq  <= RST_REF_FREQ;
      ref_div   <= RST_REF_DIV;
      lock_en   <= 1'b0;
      pump_gain <= '0;
      if_offset <= RST_IF_OFFSET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REF_FREQ:  ref_freq  <= cfg_data;
        CFG_REF_DIV:   ref_div   <= cfg_data[11:0];
        CFG_LOCK_EN:   lock_en   <= cfg_data[0];
        CFG_PUMP_GAIN: pump_gain <= cfg_data[4:0];
        CFG_IF_OFFSET: if_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Detector frequency
  logic [30:0] fpd;
  logic        fpd_busy;
  logic [29:0] half;
  logic        fpd_zero;

  fng_fpd_unit u_fpd (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_write),
    .ref_freq (ref_freq),
    .ref_div  (ref_div),
    .fpd      (fpd),
    .busy     (fpd_busy)
  );

  assign half     = fpd[30:1];
  assign fpd_zero = (fpd == '0);

  // Flow control: the whole chain moves when its tail can drain
  logic f_tail_vld;
  logic can_load;
  logic adv;

  assign adv           = !f_tail_vld | can_load;
  assign in_item.ready = adv & !fpd_busy;

  // VCO frequency and rounded dividend
  logic [30:0] fvco;
  logic [31:0] q_dividend;

  always_comb begin
    if (in_item.mode) begin
      fvco = in_item.target_frequency;
    end else if (in_item.target_frequency >= if_offset) begin
      fvco = in_item.target_frequency - if_offset;
    end else begin
      fvco = if_offset - in_item.target_frequency;
    end
    q_dividend = {1'b0, fvco} + {2'b00, half};
  end

  // Quotient chain
  logic              q_vld  [0:QUO_W];
  logic [30:0]       q_rem  [0:QUO_W];
  logic [QUO_W-1:0]  q_dvd  [0:QUO_W];
  logic [QUO_W-1:0]  q_quo  [0:QUO_W];
  logic [0:0]        q_side [0:QUO_W];

  assign q_vld[0]  = in_item.valid & in_item.ready;
  assign q_rem[0]  = '0;
  assign q_dvd[0]  = q_dividend;
  assign q_quo[0]  = '0;
  assign q_side[0] = fpd_zero;

  for (genvar i = 0; i < QUO_W; i++) begin : g_qcell
    fng_div_cell #(.DW(QUO_W), .SW(1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .fpd      (fpd),
      .vld_in   (q_vld[i]),
      .rem_in   (q_rem[i]),
      .dvd_in   (q_dvd[i]),
      .quo_in   (q_quo[i]),
      .side_in  (q_side[i]),
      .vld_out  (q_vld[i+1]),
      .rem_out  (q_rem[i+1]),
      .dvd_out  (q_dvd[i+1]),
      .quo_out  (q_quo[i+1]),
      .side_out (q_side[i+1])
    );
  end

  // Signed remainder magnitude and integer word
  logic        mid_vld;
  logic [30:0] mid_mag;
  logic        mid_neg;
  logic        mid_err;
  logic        mid_zero;
  logic [11:0] mid_int;
  logic [30:0] r0;
  logic [31:0] qv;
  logic        r_neg;

  assign r0    = q_rem[QUO_W];
  assign qv    = q_quo[QUO_W];
  assign r_neg = r0 < {1'b0, half};

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else if (adv) begin
      mid_vld <= q_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_neg  <= r_neg;
      mid_mag  <= r_neg ? ({1'b0, half} - r0) : (r0 - {1'b0, half});
      mid_err  <= (qv < INT_OFFSET) | (qv > INT_TOP);
      mid_int  <= qv[11:0] - INT_OFFSET[11:0];
      mid_zero <= q_side[QUO_W][0];
    end
  end

  // Fraction chain
  logic                     f_vld  [0:FRACTION_BITS];
  logic [30:0]              f_rem  [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] f_dvd  [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] f_quo  [0:FRACTION_BITS];
  logic [SIDE_W-1:0]        f_side [0:FRACTION_BITS];

  assign f_vld[0]  = mid_vld;
  assign f_rem[0]  = mid_mag + 31'(half >> FRACTION_BITS);
  assign f_dvd[0]  = half[FRACTION_BITS-1:0];
  assign f_quo[0]  = '0;
  assign f_side[0] = {mid_zero, mid_err, mid_neg, mid_int};

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_fcell
    fng_div_cell #(.DW(FRACTION_BITS), .SW(SIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .fpd      (fpd),
      .vld_in   (f_vld[i]),
      .rem_in   (f_rem[i]),
      .dvd_in   (f_dvd[i]),
      .quo_in   (f_quo[i]),
      .side_in  (f_side[i]),
      .vld_out  (f_vld[i+1]),
      .rem_out  (f_rem[i+1]),
      .dvd_out  (f_dvd[i+1]),
      .quo_out  (f_quo[i+1]),
      .side_out (f_side[i+1])
    );
  end

  // Apply the sign and split the fraction
  logic [FRACTION_BITS-1:0] frac;
  logic [31:0]              frac_ext;
  logic [SIDE_W-1:0]        tail_side;
  ser_load_t                load;
  ctrl_fields_t             ctrl;

  assign f_tail_vld = f_vld[FRACTION_BITS];
  assign tail_side  = f_side[FRACTION_BITS];
  assign frac       = tail_side[12] ? (~f_quo[FRACTION_BITS] + 1'b1) : f_quo[FRACTION_BITS];
  assign frac_ext   = 32'(frac);

  assign load.fpd_zero = tail_side[14];
  assign load.err      = tail_side[13];
  assign load.int_word = tail_side[11:0];
  assign load.frac_msb = frac_ext[19:8];
  assign load.frac_lsb = frac_ext[7:0];

  assign ctrl.ref_div   = ref_div;
  assign ctrl.lock_en   = lock_en;
  assign ctrl.pump_gain = pump_gain;

  fng_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .tail_valid (f_tail_vld),
    .load       (load),
    .ctrl       (ctrl),
    .can_load   (can_load),
    .out_item   (out_item)
  );

endmodule

### src/fng_checker.sv
// Port-level checks on the register word sequence, bound to the top level.
`timescale 1ns / 1ps
module fng_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_word,
  input logic        out_last,
  input logic        out_error
);
  import fng_pkg::*;

  // Hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled item changed");

  // Nothing is shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A sequence continues without gaps until its last word
  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside word sequence");

  // The error flag stays constant over one sequence
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_error == $past(out_error))
    else $error("error flag changed inside sequence");

  // The control word follows the divider word
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last && out_word[15:12] == ADDR_REF_DIV
    |=> out_word[15:12] == ADDR_CTRL)
    else $error("control word out of order");

endmodule

bind fractional_n_word_generator_top fng_checker u_fng_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .out_word  (out_item.register_word),
  .out_last  (out_item.last_word),
  .out_error (out_item.error)
);

### dv/fractional_n_word_generator_top_tb.sv
// Self-checking testbench for the fractional-N register word generator.
`timescale 1ns / 1ps
module fractional_n_word_generator_top_tb;
  import fng_pkg::*;

  localparam int FRACTION_BITS = 18;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic        mode;
    logic [30:0] target;
  } freq_request_t;

  typedef struct {
    logic [15:0] word;
    logic        last;
    logic        err;
  } reg_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_REF_FREQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fng_in_if in_item ();
  fng_out_if out_item ();

  fractional_n_word_generator_top #(.FRACTION_BITS(FRACTION_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_item(in_item.sink),
    .out_item(out_item.source)
  );

  // Local copy of the configuration
  logic [30:0] ref_freq = RST_REF_FREQ;
  logic [11:0] ref_div = RST_REF_DIV;
  logic        lock_en = 1'b0;
  logic [4:0]  gain = 5'd0;
  logic [30:0] if_offset = RST_IF_OFFSET;

  freq_request_t pending_requests[$];
  reg_word_t expected_words[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit request_taken = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    in_item.valid = 1'b0;
    in_item.mode = 1'b0;
    in_item.target_frequency = '0;
    out_item.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input reg_word_t got, input reg_word_t exp);
    $display("mismatch %s: got word %h last %b err %b, want word %h last %b err %b",
             what, got.word, got.last, got.err, exp.word, exp.last, exp.err);
    fail_count++;
  endtask

  function automatic longint unsigned detector_freq();
    return longint'(ref_freq) / (longint'(ref_div) + 1);
  endfunction

  // Work out the register word sequence for one request
  function automatic void predict_words(input logic m, input logic [30:0] tgt);
    longint unsigned fvco, fpd, half, q, mag, frac;
    longint rem;
    bit neg, er;
    logic [11:0] int_w, msb;
    logic [7:0] lsb;
    reg_word_t w;
    if (m) fvco = tgt;
    else fvco = (tgt >= if_offset) ? tgt - if_offset : if_offset - tgt;
    fpd = detector_freq();
    if (fpd == 0) begin
      w.word = 16'h0000; w.last = 1'b1; w.err = 1'b1;
      expected_words.push_back(w);
      return;
    end
    half = fpd >> 1;
    q = (fvco + half) / fpd;
    rem = longint'(fvco) - longint'(q * fpd);
    neg = rem < 0;
    mag = neg ? longint'(-rem) : longint'(rem);
    mag = ((mag << FRACTION_BITS) + half) / fpd;
    frac = neg ? (64'd0 - mag) : mag;
    frac &= (64'd1 << FRACTION_BITS) - 1;
    er = (q < 32) || (q - 32 > 4095);
    int_w = 12'((q - 32) & 64'hFFF);
    msb = 12'((frac >> 8) & 64'hFFF);
    lsb = 8'(frac & 64'hFF);
    w.last = 1'b0; w.err = er;
    w.word = {ADDR_REF_DIV, ref_div};              expected_words.push_back(w);
    w.word = {ADDR_CTRL, 6'd0, lock_en, gain};     expected_words.push_back(w);
    w.word = {ADDR_R7, 12'h000};                   expected_words.push_back(w);
    w.word = {ADDR_R8, 12'h000};                   expected_words.push_back(w);
    w.word = {ADDR_R9, 12'h000};                   expected_words.push_back(w);
    w.word = {ADDR_INT, int_w};                    expected_words.push_back(w);
    w.word = {ADDR_FRAC_LSB, 4'h0, lsb};           expected_words.push_back(w);
    w.word = {ADDR_FRAC_MSB, msb}; w.last = 1'b1;  expected_words.push_back(w);
  endfunction

  // Drive requests from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      in_item.valid <= 1'b0;
    end else if (!in_item.valid || request_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item.valid <= 1'b1;
        in_item.mode <= pending_requests[0].mode;
        in_item.target_frequency <= pending_requests[0].target;
        void'(pending_requests.pop_front());
      end else begin
        in_item.valid <= 1'b0;
      end
    end
    out_item.ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on accepted requests, check accepted words, watch for a hang
  always @(posedge clk) begin
    reg_word_t got, exp;
    request_taken = in_item.valid && in_item.ready;
    if (!rst && request_taken) predict_words(in_item.mode, in_item.target_frequency);
    if (!rst && out_item.valid && out_item.ready) begin
      got.word = out_item.register_word;
      got.last = out_item.last_word;
      got.err = out_item.error;
      if (expected_words.size() == 0) begin
        exp.word = 'x; exp.last = 'x; exp.err = 'x;
        report_mismatch("unexpected word", got, exp);
      end else begin
        exp = expected_words.pop_front();
        if (got.word !== exp.word) report_mismatch("register_word", got, exp);
        if (got.last !== exp.last) report_mismatch("last_word", got, exp);
        if (got.err !== exp.err) report_mismatch("error", got, exp);
      end
    end
    if (request_taken || (out_item.valid && out_item.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [30:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_REF_FREQ:  ref_freq = value;
      CFG_REF_DIV:   ref_div = value[11:0];
      CFG_LOCK_EN:   lock_en = value[0];
      CFG_PUMP_GAIN: gain = value[4:0];
      CFG_IF_OFFSET: if_offset = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [30:0] rf, input logic [30:0] rd, input logic [30:0] le,
                           input logic [30:0] pg, input logic [30:0] ifo);
    write_reg(CFG_REF_FREQ, rf);
    write_reg(CFG_REF_DIV, rd);
    write_reg(CFG_LOCK_EN, le);
    write_reg(CFG_PUMP_GAIN, pg);
    write_reg(CFG_IF_OFFSET, ifo);
  endtask

  task automatic add_request(input logic m, input logic [30:0] tgt);
    freq_request_t r;
    r.mode = m;
    r.target = tgt;
    pending_requests.push_back(r);
  endtask

  // Wait until every request is sent and every word has come back
  task automatic drain();
    while (pending_requests.size() != 0 || in_item.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly targets near legal divider values, some fully random
  task automatic add_random(input int count);
    longint unsigned fpd, t;
    logic m;
    for (int i = 0; i < count; i++) begin
      m = 1'($urandom_range(0, 1));
      fpd = detector_freq();
      if (fpd == 0 || $urandom_range(0, 3) == 0) begin
        t = $urandom & 32'h7FFF_FFFF;
      end else begin
        t = fpd * $urandom_range(20, 4200) + $urandom_range(0, 32'h7FFF_FFFF) % (fpd + 1);
        if (!m) t = ($urandom_range(0, 1) && t <= if_offset) ? if_offset - t : t + if_offset;
        if (t > 64'h7FFF_FFFF) t = $urandom & 32'h7FFF_FFFF;
      end
      add_request(m, 31'(t));
    end
  endtask

  task automatic set_idling(input int profile);
    case (profile % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: extremes, rounding edges, receive offset cases
    set_idling(0);
    add_request(1'b1, 31'd0);
    add_request(1'b1, 31'h7FFF_FFFF);
    add_request(1'b0, 31'd0);
    add_request(1'b0, 31'h7FFF_FFFF);
    add_request(1'b0, 31'd73350000);
    add_request(1'b1, 31'd153600000);
    add_request(1'b1, 31'd153599999);
    add_request(1'b1, 31'd151200000);
    add_request(1'b1, 31'd151199999);
    add_request(1'b1, 31'd155999999);
    add_request(1'b1, 31'd156000000);
    add_request(1'b0, 31'd73350000 + 31'd194399999);
    add_request(1'b0, 31'd73350000 - 31'd194400001);
    add_request(1'b1, 31'h5555_5555);
    add_request(1'b0, 31'h2AAA_AAAA);
    add_random(60);
    drain();

    // Extreme reference, no divider, no offset
    configure(31'h7FFF_FFFF, 31'd0, 31'd1, 31'd31, 31'd0);
    set_idling(1);
    add_request(1'b1, 31'h7FFF_FFFF);
    add_request(1'b0, 31'h7FFF_FFFF);
    add_random(70);
    drain();

    // Random settings with a pause until all words are back midway
    configure(31'($urandom_range(10000000, 40000000)), 31'($urandom_range(0, 15)), 31'd0,
              31'($urandom_range(0, 31)), 31'($urandom));
    set_idling(2);
    add_random(40);
    drain();
    add_random(40);
    drain();

    // Largest divider: quotient range top and bottom; stray bits on narrow fields
    configure(31'd19200000, 31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h7FFF_FFE5, 31'h7FFF_FFFF);
    set_idling(3);
    add_request(1'b1, 31'd4127 * 31'd4687);
    add_request(1'b1, 31'd4128 * 31'd4687);
    add_request(1'b1, 31'd32 * 31'd4687);
    add_request(1'b1, 31'd31 * 31'd4687);
    add_random(70);
    drain();

    // Zero detector frequency: error items only
    configure(31'd0, 31'd7, 31'd1, 31'd10, 31'd73350000);
    set_idling(0);
    add_random(20);
    drain();
    configure(31'd4095, 31'd4095, 31'd1, 31'd10, 31'd73350000);
    add_random(10);
    drain();

    // Typical receive setup with wide offset, then random settings
    configure(31'd26000000, 31'd1, 31'd1, 31'd17, 31'h7FFF_FFFF);
    set_idling(1);
    add_random(99);
    drain();
    configure(31'($urandom), 31'($urandom_range(0, 4095)), 31'($urandom_range(0, 1)),
              31'($urandom_range(0, 31)), 31'($urandom));
    set_idling(2);
    add_random(50);
    drain();

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
src/fng_pkg.sv
src/fng_if.sv
src/fng_fpd_unit.sv
src/fng_div_cell.sv
src/fng_serializer.sv
src/fractional_n_word_generator_top.sv
src/fng_checker.sv
dv/fractional_n_word_generator_top_tb.sv
